// ----- hw/rtl/base64_stream_encoder_assert.svh -----
// assertion macros for the base64 stream encoder
// expects clk_i and rst_ni in the scope of each use
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// condition holds at every edge out of reset
`define B64E_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define B64E_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/b64e_pkg.sv -----
// shared types, constants and the alphabet lookup for the base64 encoder
// no dependencies
package b64e_pkg;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam logic [7:0]  PAD_CHAR   = 8'h3D;
  localparam logic [5:0]  SIX_MASK   = 6'h3F;

  // one input byte: up to four characters ready to send
  typedef struct packed {
    logic [3:0][7:0] syms;
    logic [1:0]      last_idx;
    logic            fin;
  } b64e_rec_t;

  // carry state seen by the checks at the top level
  typedef struct packed {
    logic [1:0] carry_pairs;
    logic [3:0] carry_bits;
  } b64e_front_st_t;

  // standard alphabet, six bits to ascii
  function automatic logic [7:0] b64e_enc(input logic [5:0] six);
    logic [5:0] v;
    logic [7:0] r;
    v = six & SIX_MASK;
    if (v < 6'd26) begin
      r = 8'(v) + 8'd65;
    end else if (v < 6'd52) begin
      r = 8'(v) + 8'd71;
    end else if (v < 6'd62) begin
      r = 8'(v) - 8'd4;
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/b64e_front.sv -----
// front end: takes raw bytes, keeps the carry bits, builds a character record
// depends on b64e_pkg
module b64e_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               in_byte_i,
  input  logic                     in_fin_i,
  output logic                     rec_valid_o,
  input  logic                     rec_ready_i,
  output b64e_pkg::b64e_rec_t      rec_o,
  output b64e_pkg::b64e_front_st_t st_o
);

  logic [1:0] carry_pairs_q, carry_pairs_d;
  logic [3:0] carry_bits_q, carry_bits_d;
  logic       accept;

  assign in_ready_o  = rec_ready_i;
  assign rec_valid_o = in_valid_i;
  assign accept      = in_valid_i & rec_ready_i;

  always_comb begin
    rec_o.syms     = {4{b64e_pkg::PAD_CHAR}};
    rec_o.last_idx = 2'd0;
    rec_o.fin      = in_fin_i;
    carry_pairs_d  = carry_pairs_q;
    carry_bits_d   = carry_bits_q;
    case (carry_pairs_q)
      2'd1: begin
        // two held bits and the high nibble
        rec_o.syms[0] = b64e_pkg::b64e_enc({carry_bits_q[1:0], in_byte_i[7:4]});
        if (in_fin_i) begin
          rec_o.syms[1]  = b64e_pkg::b64e_enc({in_byte_i[3:0], 2'b00});
          rec_o.last_idx = 2'd2;
        end
        carry_bits_d  = in_byte_i[3:0];
        carry_pairs_d = 2'd2;
      end
      2'd2: begin
        rec_o.syms[0]  = b64e_pkg::b64e_enc({carry_bits_q, in_byte_i[7:6]});
        rec_o.syms[1]  = b64e_pkg::b64e_enc(in_byte_i[5:0]);
        rec_o.last_idx = 2'd1;
        carry_bits_d   = 4'd0;
        carry_pairs_d  = 2'd0;
      end
      default: begin
        // nothing held, an unused count drops the held bits
        rec_o.syms[0] = b64e_pkg::b64e_enc(in_byte_i[7:2]);
        if (in_fin_i) begin
          rec_o.syms[1]  = b64e_pkg::b64e_enc({in_byte_i[1:0], 4'b0000});
          rec_o.last_idx = 2'd3;
        end
        carry_bits_d  = {2'b00, in_byte_i[1:0]};
        carry_pairs_d = 2'd1;
      end
    endcase
    if (in_fin_i) begin
      carry_bits_d  = 4'd0;
      carry_pairs_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_pairs_q <= 2'd0;
      carry_bits_q  <= 4'd0;
    end else if (accept) begin
      carry_pairs_q <= carry_pairs_d;
      carry_bits_q  <= carry_bits_d;
    end
  end

  assign st_o.carry_pairs = carry_pairs_q;
  assign st_o.carry_bits  = carry_bits_q;

endmodule

// ----- hw/rtl/b64e_fifo.sv -----
// short register queue of character records between front and back
// depends on b64e_pkg
module b64e_fifo #(
  parameter int unsigned Depth = b64e_pkg::FIFO_DEPTH,
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  b64e_pkg::b64e_rec_t push_rec_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output b64e_pkg::b64e_rec_t pop_rec_o,
  output logic [CntW-1:0]     level_o
);

  b64e_pkg::b64e_rec_t entries_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     level_q, level_d;
  logic                push, pop;

  assign push_ready_o = (level_q != CntW'(Depth));
  assign pop_valid_o  = (level_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_rec_o    = entries_q[rd_ptr_q];
  assign level_o      = level_q;

  always_comb begin
    level_d = level_q;
    case ({push, pop})
      2'b10:   level_d = level_q + CntW'(1);
      2'b01:   level_d = level_q - CntW'(1);
      default: level_d = level_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      level_q <= level_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_rec_i;
    end
  end

endmodule

// ----- hw/rtl/b64e_back.sv -----
// back end: walks a record one character per cycle, while the receiver takes them, into the output register
// depends on b64e_pkg
module b64e_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rec_valid_i,
  output logic                rec_ready_o,
  input  b64e_pkg::b64e_rec_t rec_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_sym_o,
  output logic                out_last_o
);

  logic [1:0] idx_q;
  logic       out_valid_q;
  logic [7:0] sym_q;
  logic       last_q;
  logic       load, at_end;

  assign load        = rec_valid_i & (~out_valid_q | out_ready_i);
  assign at_end      = (idx_q == rec_i.last_idx);
  assign rec_ready_o = load & at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= at_end ? 2'd0 : idx_q + 2'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sym_q  <= rec_i.syms[idx_q];
      last_q <= rec_i.fin & at_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_sym_o   = sym_q;
  assign out_last_o  = last_q;

endmodule

// ----- hw/rtl/base64_stream_encoder.sv -----
// base64 stream encoder, top level: rfc 4648 alphabet with '=' padding,
// one input byte per word in, one ascii character per word out. a byte
// yields one or two characters; the byte marked with tlast also flushes the
// held bits and the padding, up to four characters in all, the last one
// marked with tlast. the output side sends one character per cycle, while
// the receiver takes them, from a single output register; the first
// character of a byte passes through the record queue and then the output
// register once the byte is taken. the input side takes a new byte whenever
// the record queue has room, also while a character still waits at the
// output.
// depends on b64e_pkg, b64e_front, b64e_fifo, b64e_back and the assert macros
`include "base64_stream_encoder_assert.svh"

module base64_stream_encoder #(
  parameter int unsigned FifoDepth = b64e_pkg::FIFO_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // final_byte
  // output stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] symbol
  output logic       m_axis_tlast    // final_symbol
);

  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  b64e_pkg::b64e_rec_t      fr_rec, bk_rec;
  b64e_pkg::b64e_front_st_t fr_st;
  logic                     fr_valid, fr_ready;
  logic                     bk_valid, bk_ready;
  logic [CntW-1:0]          q_level;

  // front: carry bits and record build
  b64e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_fin_i    (s_axis_tlast),
    .rec_valid_o (fr_valid),
    .rec_ready_i (fr_ready),
    .rec_o       (fr_rec),
    .st_o        (fr_st)
  );

  // decouples byte intake from character output
  b64e_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_rec_i   (fr_rec),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_rec_o    (bk_rec),
    .level_o      (q_level)
  );

  // back: one character per cycle while the output is taken
  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (bk_valid),
    .rec_ready_o (bk_ready),
    .rec_i       (bk_rec),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_sym_o   (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  // checks

  // a final byte always leaves the carry empty for the next message
  `B64E_ASSERT_NEXT(a_fin_clears, s_axis_tvalid && s_axis_tready && s_axis_tlast, fr_st.carry_pairs == 2'd0 && fr_st.carry_bits == 4'd0, "carry not cleared after final byte")

  // held bits agree with the pair count
  `B64E_ASSERT_ALWAYS(a_carry_shape, (fr_st.carry_pairs != 2'd3) && (fr_st.carry_pairs != 2'd0 || fr_st.carry_bits == 4'd0) && (fr_st.carry_pairs != 2'd1 || fr_st.carry_bits[3:2] == 2'b00), "carry bits inconsistent with pair count")

  // queue never overfills
  `B64E_ASSERT_ALWAYS(a_queue_level, q_level <= CntW'(FifoDepth), "record queue overfilled")

endmodule

// ----- sim/base64_stream_encoder_tb.sv -----
// testbench for base64_stream_encoder: random-gap byte stream in, character stream checked
// against a built-in base64 encoder model; depends on b64e_pkg and the encoder rtl
`timescale 1ns / 1ps

module base64_stream_encoder_tb;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;

  // held-over bit counts
  localparam logic [1:0] HOLD_NONE = 2'd0;
  localparam logic [1:0] HOLD_TWO  = 2'd1;
  localparam logic [1:0] HOLD_FOUR = 2'd2;

  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct {
    logic [7:0] data_byte;
    logic       final_byte;
  } raw_word_t;

  typedef struct {
    logic [7:0] symbol;
    logic       final_symbol;
  } char_word_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  raw_word_t  raw_q[$];
  char_word_t char_q[$];

  // encoder state mirrored by the checker
  logic [3:0] held_bits  = 4'h0;
  logic [1:0] held_pairs = HOLD_NONE;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;
  int unsigned cycles         = 0;
  int unsigned hold_left      = 0;
  logic        hold_go        = 1'b0;
  logic        hold_used      = 1'b0;

  base64_stream_encoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [7:0] b64_char(input logic [5:0] six);
    return ALPHABET[8*(63 - six) +: 8];
  endfunction

  task automatic push_char(input logic [7:0] sym);
    char_word_t w;
    w.symbol       = sym;
    w.final_symbol = 1'b0;
    char_q.insert(char_q.size(), w);
  endtask

  // characters one accepted byte produces, appended to the expectation queue
  task automatic b64_encode_byte(input logic [7:0] b, input logic fin);
    case (held_pairs)
      HOLD_TWO: begin
        push_char(b64_char({held_bits[1:0], b[7:4]}));
        held_bits  = b[3:0];
        held_pairs = HOLD_FOUR;
      end
      HOLD_FOUR: begin
        push_char(b64_char({held_bits, b[7:6]}));
        push_char(b64_char(b[5:0]));
        held_bits  = 4'h0;
        held_pairs = HOLD_NONE;
      end
      default: begin
        push_char(b64_char(b[7:2]));
        held_bits  = {2'b00, b[1:0]};
        held_pairs = HOLD_TWO;
      end
    endcase
    if (fin) begin
      // flush the leftover bits zero-filled, then pad to a group of four
      if (held_pairs == HOLD_TWO) begin
        push_char(b64_char({held_bits[1:0], 4'h0}));
        push_char(b64e_pkg::PAD_CHAR);
        push_char(b64e_pkg::PAD_CHAR);
      end else if (held_pairs == HOLD_FOUR) begin
        push_char(b64_char({held_bits, 2'b00}));
        push_char(b64e_pkg::PAD_CHAR);
      end
      char_q[char_q.size() - 1].final_symbol = 1'b1;
      held_bits  = 4'h0;
      held_pairs = HOLD_NONE;
    end
  endtask

  // driver: offers the next pending word once the current one is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
      s_axis_tlast  <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (raw_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw_q[0].data_byte;
        s_axis_tlast  <= raw_q[0].final_byte;
        raw_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, armed once from the stimulus
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_go && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on every accepted byte, check every accepted character
  always @(posedge clk_i) begin
    char_word_t want;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      b64_encode_byte(s_axis_tdata, s_axis_tlast);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (char_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word: symbol %h last %b", $time, m_axis_tdata, m_axis_tlast);
      end else begin
        want = char_q.pop_front();
        if (m_axis_tdata !== want.symbol) begin
          mismatches++;
          $display("%0t: symbol mismatch: expected %h actual %h",
                   $time, want.symbol, m_axis_tdata);
        end
        if (m_axis_tlast !== want.final_symbol) begin
          mismatches++;
          $display("%0t: last mismatch: expected %b actual %b",
                   $time, want.final_symbol, m_axis_tlast);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic push_word(input logic [7:0] b, input logic fin);
    raw_word_t w;
    w.data_byte  = b;
    w.final_byte = fin;
    raw_q.insert(raw_q.size(), w);
  endtask

  // bytes given first byte highest, last one flagged
  task automatic push_message(input logic [47:0] bytes, input int len);
    for (int i = 0; i < len; i++) begin
      push_word(bytes[8*(len - 1 - i) +: 8], i == len - 1);
    end
  endtask

  task automatic push_random(input int unsigned count);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < count) begin
      // mostly short messages, now and then a longer one
      len = ($urandom_range(7) == 0) ? $urandom_range(24, 8) : $urandom_range(5, 1);
      for (int unsigned i = 0; i < len; i++) begin
        push_word(8'($urandom), i == len - 1);
      end
      sent += len;
    end
  endtask

  task automatic wait_idle();
    while (raw_q.size() != 0 || s_axis_tvalid || char_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: all three leftover cases at the end, extreme bytes, '+' and '/'
    push_message(48'h4D616E, 3);
    push_message(48'h4D61, 2);
    push_message(48'h4D, 1);
    push_message(48'hFFFFFF, 3);
    push_message(48'hFBEFBE, 3);
    push_message(48'h00, 1);
    push_message(48'hFF, 1);
    push_message(48'h0000, 2);
    push_message(48'hFFFF, 2);
    push_message(48'h0123456789AB, 6);
    wait_idle();

    // full rate, with the receiver holding off long enough to back up the input
    hold_go = 1'b1;
    push_random(32);
    wait_idle();

    send_idle_pct = 84;
    push_random(32);
    wait_idle();

    send_idle_pct  = 0;
    recv_stall_pct = 84;
    push_random(32);
    wait_idle();

    send_idle_pct  = 25;
    recv_stall_pct = 25;
    push_random(32);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && char_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/b64e_pkg.sv
hw/rtl/b64e_front.sv
hw/rtl/b64e_fifo.sv
hw/rtl/b64e_back.sv
hw/rtl/base64_stream_encoder.sv
sim/base64_stream_encoder_tb.sv
